>>> hw/rtl/particle_cell_histogram_3d_macros.svh
// Assertion macros shared by the histogram RTL.
`ifndef PARTICLE_CELL_HISTOGRAM_3D_MACROS_SVH
`define PARTICLE_CELL_HISTOGRAM_3D_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PCH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/pch3d_pkg.sv
// Types and constants of the particle cell histogram.
package pch3d_pkg;

	localparam int MAX_CELLS = 32768;
	localparam int CELL_AW   = 15;
	localparam int COORD_W   = 11;
	localparam int MAG_W     = 33;
	localparam int INV_W     = 24;
	localparam int PROD_W    = MAG_W + INV_W;
	localparam int Q_W       = PROD_W - 32;
	localparam int NXNY_W    = 2 * COORD_W;
	localparam int TZ_W      = 3 * COORD_W;
	localparam int LIN_W     = TZ_W + 1;

	typedef enum logic [1:0] {
		FUNC_CLEAR,
		FUNC_ADD,
		FUNC_READ,
		FUNC_NOP
	} func_t;

	typedef enum logic [2:0] {
		CFG_ORIGIN_X,
		CFG_ORIGIN_Y,
		CFG_ORIGIN_Z,
		CFG_INV_CELL_SIZE,
		CFG_CELLS_X,
		CFG_CELLS_Y,
		CFG_CELLS_Z
	} cfg_idx_t;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_SUB,
		S_MUL,
		S_CHK,
		S_LIN1,
		S_LIN2,
		S_LIN3,
		S_RD,
		S_WR,
		S_RES
	} state_t;

	typedef struct packed {
		logic signed [31:0]  origin_x;
		logic signed [31:0]  origin_y;
		logic signed [31:0]  origin_z;
		logic [INV_W-1:0]    inv_cell_size;
		logic [COORD_W-1:0]  cells_x;
		logic [COORD_W-1:0]  cells_y;
		logic [COORD_W-1:0]  cells_z;
	} cfg_t;

	typedef struct packed {
		logic  cap;
		logic  sub;
		logic  mul;
		logic  chk;
		axis_t axis;
		logic  lin1;
		logic  lin2;
		logic  lin3;
		logic  rd;
		logic  wr;
		logic  clr_wr;
		logic  res_ld;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  outside;
		logic  clr_last;
		logic  res_block;
	} status_t;

endpackage

>>> hw/rtl/pch3d_cfg.sv
// Configuration register file of the particle cell histogram.
module pch3d_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output pch3d_pkg::cfg_t   cfg
);
	import pch3d_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.origin_z      <= '0;
			cfg_q.inv_cell_size <= INV_W'(21845);
			cfg_q.cells_x       <= COORD_W'(32);
			cfg_q.cells_y       <= COORD_W'(32);
			cfg_q.cells_z       <= COORD_W'(32);
		end else if (wr_en) begin
			case (cfg_index)
				CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data;
				CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data;
				CFG_ORIGIN_Z:      cfg_q.origin_z      <= cfg_data;
				CFG_INV_CELL_SIZE: cfg_q.inv_cell_size <= cfg_data[INV_W-1:0];
				CFG_CELLS_X:       cfg_q.cells_x       <= cfg_data[COORD_W-1:0];
				CFG_CELLS_Y:       cfg_q.cells_y       <= cfg_data[COORD_W-1:0];
				CFG_CELLS_Z:       cfg_q.cells_z       <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/pch3d_dp.sv
// Datapath: axis scaling, cell index, counter memory and result register.
`include "particle_cell_histogram_3d_macros.svh"

module pch3d_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pch3d_pkg::cmd_t               cmd,
	output pch3d_pkg::status_t            st,
	input  pch3d_pkg::cfg_t               cfg,
	input  logic [1:0]                    func,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	input  logic [pch3d_pkg::CELL_AW-1:0] read_cell,
	input  logic                          result_stall,
	output logic                          result_valid,
	output logic [7:0]                    cell_count,
	output logic [pch3d_pkg::CELL_AW-1:0] cell_number,
	output logic                          outside_box
);
	import pch3d_pkg::*;

	func_t               func_q;
	logic [31:0]         pos_x_q, pos_y_q, pos_z_q;
	logic [CELL_AW-1:0]  read_cell_q;
	logic [MAG_W-1:0]    mag_q;
	logic                neg_q;
	logic [PROD_W-1:0]   prod_q;
	logic                outside_q;
	logic [COORD_W-1:0]  cx_q, cy_q, cz_q;
	logic [NXNY_W-1:0]   nxny_q, ty_q;
	logic [TZ_W-1:0]     tz_q;
	logic [CELL_AW-1:0]  lin_q;
	logic [CELL_AW-1:0]  clr_addr_q;
	logic [7:0]          rd_q;
	logic                res_valid_q;
	logic [7:0]          count_q;
	logic [CELL_AW-1:0]  number_q;
	logic                outbox_q;

	logic [7:0]          mem [MAX_CELLS];

	logic [31:0]         pos_sel, org_sel;
	logic [COORD_W-1:0]  n_sel;
	logic [MAG_W-1:0]    diff, mag;
	logic [Q_W-1:0]      q;
	logic                bad;
	logic [LIN_W-1:0]    lin;
	logic [CELL_AW-1:0]  rd_addr;
	logic [7:0]          inc;

	always_comb begin
		case (cmd.axis)
			AX_X: begin
				pos_sel = pos_x_q;
				org_sel = cfg.origin_x;
				n_sel   = cfg.cells_x;
			end
			AX_Y: begin
				pos_sel = pos_y_q;
				org_sel = cfg.origin_y;
				n_sel   = cfg.cells_y;
			end
			AX_Z: begin
				pos_sel = pos_z_q;
				org_sel = cfg.origin_z;
				n_sel   = cfg.cells_z;
			end
			default: begin
				pos_sel = pos_x_q;
				org_sel = cfg.origin_x;
				n_sel   = cfg.cells_x;
			end
		endcase
	end

	assign diff = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};
	assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
	assign q    = prod_q[PROD_W-1:32];
	assign bad  = (neg_q && (q != '0)) || (q >= Q_W'(n_sel));
	assign lin  = LIN_W'(cx_q) + LIN_W'(ty_q) + LIN_W'(tz_q);
	assign rd_addr = (func_q == FUNC_READ) ? read_cell_q : lin_q;
	assign inc  = rd_q + 8'd1;

	// request capture and index arithmetic
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q      <= func_t'(func);
			pos_x_q     <= pos_x;
			pos_y_q     <= pos_y;
			pos_z_q     <= pos_z;
			read_cell_q <= read_cell;
		end
		if (cmd.sub) begin
			mag_q <= mag;
			neg_q <= diff[MAG_W-1];
		end
		if (cmd.mul)
			prod_q <= PROD_W'(mag_q) * PROD_W'(cfg.inv_cell_size);
		if (cmd.chk) begin
			case (cmd.axis)
				AX_X:    cx_q <= q[COORD_W-1:0];
				AX_Y:    cy_q <= q[COORD_W-1:0];
				AX_Z:    cz_q <= q[COORD_W-1:0];
				default: cx_q <= q[COORD_W-1:0];
			endcase
		end
		if (cmd.lin1) begin
			nxny_q <= NXNY_W'(cfg.cells_x) * NXNY_W'(cfg.cells_y);
			ty_q   <= NXNY_W'(cy_q) * NXNY_W'(cfg.cells_x);
		end
		if (cmd.lin2)
			tz_q <= TZ_W'(cz_q) * TZ_W'(nxny_q);
		if (cmd.lin3)
			lin_q <= lin[CELL_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outside_q <= 1'b0;
		end else if (cmd.cap) begin
			outside_q <= 1'b0;
		end else if (cmd.chk && bad) begin
			outside_q <= 1'b1;
		end else if (cmd.lin3 && (lin[LIN_W-1:CELL_AW] != '0)) begin
			outside_q <= 1'b1;
		end
	end

	// counter store, one access per cycle
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			mem[clr_addr_q] <= 8'd0;
		else if (cmd.wr)
			mem[lin_q] <= inc;
		if (cmd.rd)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr_wr)
			clr_addr_q <= clr_addr_q + CELL_AW'(1);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.res_ld)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			if (cmd.wr) begin
				count_q  <= inc;
				number_q <= lin_q;
				outbox_q <= 1'b0;
			end else if (func_q == FUNC_READ) begin
				count_q  <= rd_q;
				number_q <= read_cell_q;
				outbox_q <= 1'b0;
			end else if (func_q == FUNC_ADD) begin
				count_q  <= '0;
				number_q <= '0;
				outbox_q <= 1'b1;
			end else begin
				count_q  <= '0;
				number_q <= '0;
				outbox_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign cell_count   = count_q;
	assign cell_number  = number_q;
	assign outside_box  = outbox_q;

	assign st.func      = func_q;
	assign st.outside   = outside_q;
	assign st.clr_last  = (clr_addr_q == CELL_AW'(MAX_CELLS - 1));
	assign st.res_block = res_valid_q && result_stall;

	`PCH_ASSERT_IMP(a_wr_inside, cmd.wr, !outside_q && (func_q == FUNC_ADD))
	`PCH_ASSERT_IMP(a_out_zero, res_valid_q && outbox_q, (count_q == '0) && (number_q == '0))

endmodule

>>> hw/rtl/pch3d_ctrl.sv
// Controller state machine of the particle cell histogram.
`include "particle_cell_histogram_3d_macros.svh"

module pch3d_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           func,
	output pch3d_pkg::cmd_t      cmd,
	input  pch3d_pkg::status_t   st
);
	import pch3d_pkg::*;

	state_t state_q, state_d;
	axis_t  axis_q;
	logic   clr_item_q;
	logic   accept;

	assign accept = (state_q == S_IDLE) && item_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:  if (st.clr_last) state_d = clr_item_q ? S_RES : S_IDLE;
			S_IDLE: begin
				if (item_valid) begin
					case (func_t'(func))
						FUNC_CLEAR: state_d = S_CLR;
						FUNC_ADD:   state_d = S_SUB;
						FUNC_READ:  state_d = S_RD;
						default:    state_d = S_RES;
					endcase
				end
			end
			S_SUB:  state_d = S_MUL;
			S_MUL:  state_d = S_CHK;
			S_CHK:  state_d = (axis_q == AX_Z) ? S_LIN1 : S_SUB;
			S_LIN1: state_d = S_LIN2;
			S_LIN2: state_d = S_LIN3;
			S_LIN3: state_d = S_RD;
			S_RD:   state_d = ((st.func == FUNC_ADD) && !st.outside) ? S_WR : S_RES;
			S_WR:   if (!st.res_block) state_d = S_IDLE;
			S_RES:  if (!st.res_block) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.axis   = axis_q;
		item_stall = 1'b1;
		case (state_q)
			S_CLR:  cmd.clr_wr = 1'b1;
			S_IDLE: begin
				item_stall = 1'b0;
				cmd.cap    = item_valid;
			end
			S_SUB:  cmd.sub  = 1'b1;
			S_MUL:  cmd.mul  = 1'b1;
			S_CHK:  cmd.chk  = 1'b1;
			S_LIN1: cmd.lin1 = 1'b1;
			S_LIN2: cmd.lin2 = 1'b1;
			S_LIN3: cmd.lin3 = 1'b1;
			S_RD:   cmd.rd   = 1'b1;
			S_WR: begin
				cmd.wr     = !st.res_block;
				cmd.res_ld = !st.res_block;
			end
			S_RES:  cmd.res_ld = !st.res_block;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			axis_q     <= AX_X;
			clr_item_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				clr_item_q <= (func_t'(func) == FUNC_CLEAR);
			if (state_q == S_CHK) begin
				case (axis_q)
					AX_X:    axis_q <= AX_Y;
					AX_Y:    axis_q <= AX_Z;
					default: axis_q <= AX_X;
				endcase
			end
		end
	end

	`PCH_ASSERT_NEXT(a_clr_done, (state_q == S_CLR) && st.clr_last, (state_q == S_IDLE) || (state_q == S_RES))
	`PCH_ASSERT_IMP(a_ld_free, cmd.res_ld, !st.res_block)
	`PCH_ASSERT_IMP(a_axis_lin, state_q == S_LIN1, axis_q == AX_X)

endmodule

>>> hw/rtl/particle_cell_histogram_3d.sv
// Top level of the particle cell histogram: 3D grid binning with 8-bit counters.
//
//  channel   handshake                fields
//  item      item_valid / item_stall  func, pos_x, pos_y, pos_z, read_cell
//  result    result_valid / result_stall  cell_count, cell_number, outside_box
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// An add request makes three passes of the shared subtract/multiply/check unit, one per
// axis, then the index arithmetic (LIN1, LIN2, LIN3) and a read-modify-write of the
// single-port counter memory, whose write is skipped for a position outside the grid.
// The next request is taken once the result is loaded. A read reads one counter; a clear
// request walks all 32768 counters, one per cycle, as reset does before any request.
// A stalled result is held; the next request runs on and waits only at its result cycle.
module particle_cell_histogram_3d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    func,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	input  logic [pch3d_pkg::CELL_AW-1:0] read_cell,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [7:0]                    cell_count,
	output logic [pch3d_pkg::CELL_AW-1:0] cell_number,
	output logic                          outside_box,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);
	import pch3d_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	pch3d_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pch3d_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.func       (func),
		.cmd        (cmd),
		.st         (st)
	);

	pch3d_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg          (cfg),
		.func         (func),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.read_cell    (read_cell),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.cell_count   (cell_count),
		.cell_number  (cell_number),
		.outside_box  (outside_box)
	);

endmodule
